// ----- src/tcr_pkg.sv -----
// Shared constants and types for the totalistic ring successor block.
package tcr_pkg;

    localparam int FIELD_BITS    = 16;
    localparam int IDX_W         = $clog2(FIELD_BITS);
    localparam int RULE_W        = 8;
    localparam int LEN_W         = 5;
    localparam int RADIUS        = 3;
    localparam int NBHD          = 2 * RADIUS + 1;
    localparam int SUM_W         = $clog2(RULE_W);
    localparam int MAX_CELLS_DEF = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = RULE_W;

    localparam logic [RULE_W-1:0] RULE_BITS_RST   = '0;
    localparam logic [LEN_W-1:0]  RING_LENGTH_RST = LEN_W'(14);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RULE_BITS   = CFG_IDX_W'(0),
        CFG_RING_LENGTH = CFG_IDX_W'(1)
    } t_cfg_reg;

    typedef struct packed {
        logic [RULE_W-1:0] rule;
        logic [LEN_W-1:0]  len;
    } t_lane_cfg;

endpackage

// ----- src/tcr_in_if.sv -----
// Input channel: one ring state per item.
interface tcr_in_if;
    logic                            valid;
    logic                            ready;
    logic [tcr_pkg::FIELD_BITS-1:0]  state_word;

    modport source (output valid, output state_word, input ready);
    modport sink   (input valid, input state_word, output ready);
endinterface

// ----- src/tcr_out_if.sv -----
// Output channel: one successor ring state per item.
interface tcr_out_if;
    logic                            valid;
    logic                            ready;
    logic [tcr_pkg::FIELD_BITS-1:0]  next_word;

    modport source (output valid, output next_word, input ready);
    modport sink   (input valid, input next_word, output ready);
endinterface

// ----- src/tcr_lane.sv -----
// One cell lane: neighborhood sum around a fixed bit position and rule lookup.
module tcr_lane #(
    parameter int BIT = 0
) (
    input  logic [tcr_pkg::FIELD_BITS-1:0] i_word,
    input  tcr_pkg::t_lane_cfg             i_cfg,
    output logic                           o_bit
);

    localparam int VW = tcr_pkg::LEN_W + 2;
    localparam logic [tcr_pkg::LEN_W-1:0] BIT_POS = tcr_pkg::LEN_W'(BIT);

    logic signed [VW-1:0]            v;
    logic signed [VW-1:0]            len_s;
    logic signed [VW-1:0]            m;
    logic [tcr_pkg::SUM_W-1:0]       sum;

    always_comb begin
        len_s = signed'({2'b00, i_cfg.len});
        sum   = '0;
        v     = '0;
        m     = '0;
        for (int d = 0; d < tcr_pkg::NBHD; d++) begin
            v = VW'(BIT + d - tcr_pkg::RADIUS);
            // wrap the neighbor position onto the ring; one correction suffices
            // from three cells up, shorter rings wrap by mask or collapse
            if (i_cfg.len <= tcr_pkg::LEN_W'(1)) begin
                m = '0;
            end else if (i_cfg.len == tcr_pkg::LEN_W'(2)) begin
                m = VW'({1'b0, v[0]});
            end else if (v < 0) begin
                m = v + len_s;
            end else if (v >= len_s) begin
                m = v - len_s;
            end else begin
                m = v;
            end
            sum = sum + tcr_pkg::SUM_W'(i_word[m[tcr_pkg::IDX_W-1:0]]);
        end
        o_bit = i_cfg.rule[sum] && (BIT_POS < i_cfg.len);
    end

endmodule

// ----- src/tcr_merge.sv -----
// Merge lane bits into a result word and hold it in a two-entry output queue.
module tcr_merge #(
    parameter int LANES = tcr_pkg::MAX_CELLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LANES-1:0]  i_lane_bits,
    input  logic              i_push,
    output logic              o_ready,
    tcr_out_if.source         o_out
);

    logic [tcr_pkg::FIELD_BITS-1:0] w_word;
    logic [tcr_pkg::FIELD_BITS-1:0] r_main;
    logic [tcr_pkg::FIELD_BITS-1:0] r_skid;
    logic                           r_main_v;
    logic                           r_skid_v;
    logic                           w_take;
    logic                           w_pop;

    assign w_word  = tcr_pkg::FIELD_BITS'(i_lane_bits);
    assign o_ready = !r_skid_v;
    assign w_take  = i_push && !r_skid_v;
    assign w_pop   = r_main_v && o_out.ready;

    assign o_out.valid     = r_main_v;
    assign o_out.next_word = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || w_pop) begin
            // main slot frees up: refill from skid first, else from the lanes
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= w_take;
            end
        end else if (w_take) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || w_pop) begin
            r_main <= r_skid_v ? r_skid : w_word;
        end
        if (w_take && r_main_v && !w_pop) begin
            r_skid <= w_word;
        end
    end

endmodule

// ----- src/totalistic_ca_ring_successor.sv -----
// Binary radius-3 totalistic ring successor: one lane per cell, merged result word.
//
// Takes one ring state per item and returns the state one generation later. Every
// cell has its own lane that sums the cell and its three neighbors on each side,
// wrapping modulo the ring length, and picks the matching bit of rule_bits. All
// lanes work on the same item in the cycle it is accepted and the merged word is
// registered into the output queue, so a new item can enter every clock while the
// queue has room: throughput is one item per cycle. A two-entry output queue keeps
// input ready high while one finished result waits. Ring lengths above the lane
// count saturate to it; bits at and above the ring length read as zero. Write the
// configuration only while no item is in flight.
module totalistic_ca_ring_successor #(
    parameter int MAX_CELLS = tcr_pkg::MAX_CELLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tcr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    tcr_in_if.sink                             i_in,
    tcr_out_if.source                          o_out
);

    localparam int LANES = (MAX_CELLS < tcr_pkg::FIELD_BITS) ? MAX_CELLS
                                                             : tcr_pkg::FIELD_BITS;
    localparam logic [tcr_pkg::LEN_W-1:0] LEN_LIM = tcr_pkg::LEN_W'(LANES);

    logic [tcr_pkg::RULE_W-1:0] r_rule_bits;
    logic [tcr_pkg::LEN_W-1:0]  r_ring_length;
    tcr_pkg::t_lane_cfg         w_cfg;
    logic [LANES-1:0]           w_lane_bits;
    logic                       w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_bits   <= tcr_pkg::RULE_BITS_RST;
            r_ring_length <= tcr_pkg::RING_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcr_pkg::CFG_RULE_BITS:   r_rule_bits   <= i_cfg_data[tcr_pkg::RULE_W-1:0];
                tcr_pkg::CFG_RING_LENGTH: r_ring_length <= i_cfg_data[tcr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate the ring length to the number of lanes
    assign w_cfg.rule = r_rule_bits;
    assign w_cfg.len  = (r_ring_length > LEN_LIM) ? LEN_LIM : r_ring_length;

    for (genvar b = 0; b < LANES; b++) begin : g_lane
        tcr_lane #(
            .BIT (b)
        ) u_lane (
            .i_word (i_in.state_word),
            .i_cfg  (w_cfg),
            .o_bit  (w_lane_bits[b])
        );
    end

    tcr_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lane_bits (w_lane_bits),
        .i_push      (i_in.valid),
        .o_ready     (w_ready),
        .o_out       (o_out)
    );

    assign i_in.ready = w_ready;

endmodule

// ----- src/tcr_checker.sv -----
// Port-level checks for the totalistic ring successor, bound to the top level.
module tcr_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [tcr_pkg::FIELD_BITS-1:0] i_next_word
);

    // reset empties the output queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input stalls only when a result is waiting
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

    // an item entering an empty block shows up on the output in the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_out_valid) |=> i_out_valid)
        else $error("accepted item not delivered after one cycle");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_next_word)))
        else $error("stalled result changed");

endmodule

bind totalistic_ca_ring_successor tcr_checker u_tcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_next_word (o_out.next_word)
);

// ----- tb/tcr_successor_check.sv -----
// Watches the ring successor channels, predicts each next ring state and compares it.
module tcr_successor_check #(
    parameter int MAX_CELLS = tcr_pkg::MAX_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tcr_in_if                              in_ch,
    tcr_out_if                             out_ch,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [tcr_pkg::FIELD_BITS-1:0] state_word;
        logic [tcr_pkg::FIELD_BITS-1:0] next_word;
    } t_successor;

    t_successor                   pending_successors[$];
    logic [tcr_pkg::RULE_W-1:0]   rule_copy = tcr_pkg::RULE_BITS_RST;
    logic [tcr_pkg::LEN_W-1:0]    len_copy  = tcr_pkg::RING_LENGTH_RST;
    int                           mismatches = 0;

    // One generation of the ring: each cell sums itself and three neighbors per side.
    function automatic logic [tcr_pkg::FIELD_BITS-1:0] next_generation(
        logic [tcr_pkg::FIELD_BITS-1:0] cells,
        logic [tcr_pkg::RULE_W-1:0]     rule,
        logic [tcr_pkg::LEN_W-1:0]      len_reg
    );
        int                             len;
        int                             idx;
        int                             sum;
        logic [tcr_pkg::FIELD_BITS-1:0] result;
        len = int'(len_reg);
        if (len > MAX_CELLS) len = MAX_CELLS;
        if (len > tcr_pkg::FIELD_BITS) len = tcr_pkg::FIELD_BITS;
        result = '0;
        for (int i = 0; i < len; i++) begin
            sum = 0;
            for (int d = -tcr_pkg::RADIUS; d <= tcr_pkg::RADIUS; d++) begin
                // wrap modulo the ring; short rings count a cell more than once
                idx = (i + d + tcr_pkg::RADIUS * len) % len;
                sum += int'(cells[len - 1 - idx]);
            end
            if (rule[sum]) begin
                result[len - 1 - i] = 1'b1;
            end
        end
        return result;
    endfunction

    always @(posedge i_clk) begin
        t_successor want;
        t_successor got;
        if (!i_rst_n) begin
            pending_successors.delete();
            rule_copy = tcr_pkg::RULE_BITS_RST;
            len_copy  = tcr_pkg::RING_LENGTH_RST;
            o_pending <= 0;
        end else begin
            // retire the oldest result before taking a new item
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_successors.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual next_word %h",
                             $realtime, out_ch.next_word);
                end else begin
                    want = pending_successors.pop_front();
                    if (out_ch.next_word !== want.next_word) begin
                        mismatches++;
                        $display("%0t: next_word for state %h: expected %h, actual %h",
                                 $realtime, want.state_word, want.next_word,
                                 out_ch.next_word);
                    end
                end
            end
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                got.state_word = in_ch.state_word;
                got.next_word  = next_generation(in_ch.state_word, rule_copy, len_copy);
                pending_successors.push_back(got);
            end
            if (i_cfg_we === 1'b1) begin
                case (tcr_pkg::t_cfg_reg'(i_cfg_idx))
                    tcr_pkg::CFG_RULE_BITS: begin
                        rule_copy = i_cfg_data[tcr_pkg::RULE_W-1:0];
                    end
                    tcr_pkg::CFG_RING_LENGTH: begin
                        len_copy = i_cfg_data[tcr_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            o_pending <= pending_successors.size();
        end
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the ring successor testbench: clock, reset, stimulus, idling and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_ITEMS  = 100;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [tcr_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [tcr_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             fail_count;
    int                             pending;
    int                             cycles = 0;
    bit                             steady_in  = 1'b0;
    bit                             steady_out = 1'b0;

    tcr_in_if  in_ch ();
    tcr_out_if out_ch ();

    totalistic_ca_ring_successor #(
        .MAX_CELLS (tcr_pkg::MAX_CELLS_DEF)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tcr_successor_check #(
        .MAX_CELLS (tcr_pkg::MAX_CELLS_DEF)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("totalistic_ca_ring_successor: mismatch");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [tcr_pkg::FIELD_BITS-1:0] w);
        int gap;
        gap = steady_in ? 0 : idle_length();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.state_word <= w;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
    endtask

    // Hold off until every expected successor has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input tcr_pkg::t_cfg_reg idx,
                             input logic [tcr_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [tcr_pkg::RULE_W-1:0] rule,
                                input logic [tcr_pkg::CFG_DATA_W-1:0] len_data);
        drain();
        write_reg(tcr_pkg::CFG_RULE_BITS, rule);
        write_reg(tcr_pkg::CFG_RING_LENGTH, len_data);
        cfg_we <= 1'b0;
    endtask

    // Output side: bursts of ready with random stalls between them.
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            stall = steady_out ? 0 : idle_length();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin
        logic [tcr_pkg::RULE_W-1:0]     rule;
        logic [tcr_pkg::LEN_W-1:0]      len;
        logic [tcr_pkg::FIELD_BITS-1:0] w;
        int                             sel;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_idx          <= tcr_pkg::CFG_RULE_BITS;
        cfg_data         <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.state_word <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ring length still at its reset value: all-ones rule gives 14 ones
        write_reg(tcr_pkg::CFG_RULE_BITS, 8'hFF);
        cfg_we <= 1'b0;
        send_word(16'h0000);
        send_word(16'hFFFF);

        apply_config(8'h00, 8'd16);
        send_word(16'hFFFF);

        apply_config(8'h6A, 8'd16);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h8000);
        send_word(16'h0001);
        send_word(16'hAAAA);
        send_word(16'h5555);

        // exactly one neighborhood wide; high bits must be ignored
        apply_config(8'hE8, 8'd7);
        send_word(16'h0040);
        send_word(16'h007F);
        send_word(16'hFFAA);

        // short rings count cells more than once
        apply_config(8'h5B, 8'd5);
        send_word(16'h0011);
        send_word(16'hFFE5);
        apply_config(8'h3C, 8'd3);
        send_word(16'h0005);
        apply_config(8'h81, 8'd1);
        send_word(16'h0001);
        send_word(16'h0000);

        // zero length always gives zero
        apply_config(8'hFF, 8'd0);
        send_word(16'hFFFF);

        // lengths above the lane count saturate
        apply_config(8'hC7, 8'd31);
        send_word(16'h1234);
        send_word(16'hFEDC);
        apply_config(8'h99, 8'd17);
        send_word(16'h8001);

        apply_config(8'h55, 8'd8);
        send_word(16'hFF3C);

        for (int p = 0; p < RAND_PHASES; p++) begin
            rule = tcr_pkg::RULE_W'($urandom_range(0, 255));
            sel  = $urandom_range(0, 9);
            if (sel < 7) len = tcr_pkg::LEN_W'($urandom_range(5, 16));
            else if (sel == 7) len = tcr_pkg::LEN_W'($urandom_range(0, 4));
            else if (sel == 8) len = tcr_pkg::LEN_W'($urandom_range(17, 31));
            else len = tcr_pkg::LEN_W'(16);
            if (p == 0) len = tcr_pkg::LEN_W'(5);
            if (p == RAND_PHASES - 1) len = tcr_pkg::LEN_W'(16);
            apply_config(rule, {3'($urandom_range(0, 7)), len});
            steady_in  = ($urandom_range(0, 3) == 0);
            steady_out = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == PHASE_ITEMS / 2) begin
                    drain();
                end
                sel = $urandom_range(0, 9);
                case (sel)
                    6: w = 16'h0001 << $urandom_range(0, 15);
                    7: w = ~(16'h0001 << $urandom_range(0, 15));
                    8: w = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                    9: w = tcr_pkg::FIELD_BITS'($urandom) & tcr_pkg::FIELD_BITS'($urandom);
                    default: w = tcr_pkg::FIELD_BITS'($urandom);
                endcase
                send_word(w);
            end
        end

        steady_in  = 1'b0;
        steady_out = 1'b0;
        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("totalistic_ca_ring_successor: match");
        end else begin
            $display("totalistic_ca_ring_successor: mismatch");
        end
        $finish;
    end

endmodule
